>>> sv/biquad_direct_form_one_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// biquad filter assertion macros
// shared property forms for the biquad filter unit, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef BIQUAD_DIRECT_FORM_ONE_FILTER_UNIT_MACROS_SVH
`define BIQUAD_DIRECT_FORM_ONE_FILTER_UNIT_MACROS_SVH

// same-cycle implication
`define BQD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("biquad unit: same-cycle check failed");

// next-cycle implication
`define BQD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("biquad unit: next-cycle check failed");

`endif

>>> sv/bqd_pkg.sv
// ----------------------------------------------------------------------------
// biquad filter package
// sizes, register indexes and fixed constants of the direct form one biquad
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bqd_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int COEF_BITS    = 32;
    localparam int COEF_FRAC    = COEF_BITS - 3;
    localparam int CFG_IDX_BITS = 3;

    // product, accumulator and rounded result widths
    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS  = SAMPLE_BITS + COEF_BITS + 3;
    localparam int RES_BITS  = ACC_BITS - COEF_FRAC;

    // priming divider widths
    localparam int MAG_BITS  = SAMPLE_BITS + COEF_BITS;
    localparam int DEN_BITS  = COEF_BITS + 2;
    localparam int DMAG_BITS = COEF_BITS + 1;
    localparam int QUO_BITS  = SAMPLE_BITS + 1;
    localparam int DCNT_BITS = $clog2(MAG_BITS);

    localparam int STEP_BITS = 3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic [CFG_IDX_BITS-1:0]       cfg_idx_t;

    localparam cfg_idx_t REG_FF_GAIN_0 = 3'd0;
    localparam cfg_idx_t REG_FF_GAIN_1 = 3'd1;
    localparam cfg_idx_t REG_FF_GAIN_2 = 3'd2;
    localparam cfg_idx_t REG_FB_GAIN_1 = 3'd3;
    localparam cfg_idx_t REG_FB_GAIN_2 = 3'd4;

    localparam coef_t COEF_ONE = coef_t'(COEF_BITS'(1) << COEF_FRAC);

    localparam logic signed [DEN_BITS-1:0] DEN_ONE = DEN_BITS'(1) << COEF_FRAC;
    localparam logic signed [ACC_BITS-1:0] ACC_ROUND = ACC_BITS'(1) << (COEF_FRAC - 1);

    localparam logic signed [RES_BITS-1:0] SAT_MAX =
        {{(RES_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [RES_BITS-1:0] SAT_MIN =
        {{(RES_BITS - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    localparam logic [QUO_BITS:0] LIM_NEG = (QUO_BITS + 1)'(1) << (SAMPLE_BITS - 1);
    localparam logic [QUO_BITS:0] LIM_POS = LIM_NEG - (QUO_BITS + 1)'(1);

    localparam logic [STEP_BITS-1:0] STEP_FILT_LAST  = 3'd5;
    localparam logic [STEP_BITS-1:0] STEP_PRIME_LAST = 3'd3;
    localparam logic [DCNT_BITS-1:0] DCNT_LAST       = DCNT_BITS'(MAG_BITS - 1);

endpackage

`default_nettype wire

>>> sv/biquad_direct_form_one_filter_unit.sv
// ----------------------------------------------------------------------------
// biquad direct form one filter unit
// second-order iir filter on one shared multiply-accumulate, with a bit-serial
// divider that primes the output history for a steady input level
// ----------------------------------------------------------------------------
//   channel   direction   handshake             payload
//   in        in          in_valid / in_ready   kind, sample
//   out       out         out_valid / out_ready filtered
//   cfg       in          cfg_write             cfg_index, cfg_data
//
// a filter transfer runs through the transfer cycle, five products through the
// one 32x24 multiplier, a step to drain the product register and one to round out.
// a prime transfer runs through the transfer cycle, three products, a step to
// drain them, one for the denominator, the 56-step restoring divider and one to
// write back; with a zero denominator it ends after the denominator step.
// reset loads b0 = 1.0, the other gains 0 and clears all histories.
// a finished sample waits in the output register; the unit holds in its
// finish step only when a second result is due before the first is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "biquad_direct_form_one_filter_unit_macros.svh"

module biquad_direct_form_one_filter_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               kind,
    input  wire bqd_pkg::sample_t   sample,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bqd_pkg::sample_t        filtered,
    input  wire logic               cfg_write,
    input  wire bqd_pkg::cfg_idx_t  cfg_index,
    input  wire bqd_pkg::coef_t     cfg_data
);

    import bqd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_DEN  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_PFIN = 3'd5;

    // control registers
    logic [2:0]           state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [DCNT_BITS-1:0] dcnt_reg, dcnt_next;
    logic                 out_valid_reg, out_valid_next;
    coef_t                ff_gain_0_reg, ff_gain_1_reg, ff_gain_2_reg;
    coef_t                fb_gain_1_reg, fb_gain_2_reg;
    sample_t              in_hist_1_reg, in_hist_1_next;
    sample_t              in_hist_2_reg, in_hist_2_next;
    sample_t              out_hist_1_reg, out_hist_1_next;
    sample_t              out_hist_2_reg, out_hist_2_next;

    // datapath registers
    logic                          kind_reg, kind_next;
    sample_t                       x_reg, x_next;
    logic signed [PROD_BITS-1:0]   prod_reg, prod_next;
    logic                          prod_sub_reg, prod_sub_next;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;
    logic [DMAG_BITS-1:0]          dmag_reg, dmag_next;
    logic                          neg_reg, neg_next;
    logic [MAG_BITS-1:0]           dvd_reg, dvd_next;
    logic [DMAG_BITS-1:0]          rem_reg, rem_next;
    logic [QUO_BITS-1:0]           quo_reg, quo_next;
    logic                          ovf_reg, ovf_next;
    sample_t                       out_data_reg, out_data_next;

    // combinational helpers
    coef_t                         mul_coef;
    sample_t                       mul_op;
    logic signed [PROD_BITS-1:0]   mul_prod;
    logic [STEP_BITS-1:0]          step_last;
    logic signed [RES_BITS-1:0]    res;
    sample_t                       res_sat;
    logic signed [DEN_BITS-1:0]    den;
    logic signed [ACC_BITS-1:0]    acc_mag;
    logic [DMAG_BITS:0]            trial;
    logic                          fits;
    logic                          round_up;
    logic [QUO_BITS:0]             q_rnd;
    logic [QUO_BITS:0]             q_lim;
    logic [QUO_BITS:0]             q_sat;
    logic [QUO_BITS:0]             q_signed;
    logic                          out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign filtered  = out_data_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (step_reg)
            3'd0:
            begin
                mul_coef = ff_gain_0_reg;
                mul_op   = x_reg;
            end
            3'd1:
            begin
                mul_coef = ff_gain_1_reg;
                mul_op   = kind_reg ? x_reg : in_hist_1_reg;
            end
            3'd2:
            begin
                mul_coef = ff_gain_2_reg;
                mul_op   = kind_reg ? x_reg : in_hist_2_reg;
            end
            3'd3:
            begin
                mul_coef = fb_gain_1_reg;
                mul_op   = out_hist_1_reg;
            end
            default:
            begin
                mul_coef = fb_gain_2_reg;
                mul_op   = out_hist_2_reg;
            end
        endcase
    end

    assign mul_prod  = mul_coef * mul_op;
    assign step_last = kind_reg ? STEP_PRIME_LAST : STEP_FILT_LAST;

    // round is already in the accumulator, so only shift and clamp
    assign res = RES_BITS'(acc_reg >>> COEF_FRAC);

    always_comb
    begin
        priority if (res > SAT_MAX)
            res_sat = sample_t'(SAT_MAX);
        else if (res < SAT_MIN)
            res_sat = sample_t'(SAT_MIN);
        else
            res_sat = sample_t'(res);
    end

    assign den     = DEN_ONE + DEN_BITS'(fb_gain_1_reg) + DEN_BITS'(fb_gain_2_reg);
    assign acc_mag = acc_reg[ACC_BITS-1] ? -acc_reg : acc_reg;

    // one restoring division step
    assign trial = {rem_reg, dvd_reg[MAG_BITS-1]};
    assign fits  = (trial >= {1'b0, dmag_reg});

    // round half away from zero on the magnitude, then clamp
    assign round_up = ({rem_reg, 1'b0} >= {1'b0, dmag_reg});
    assign q_rnd    = {1'b0, quo_reg} + (QUO_BITS + 1)'(round_up);
    assign q_lim    = neg_reg ? LIM_NEG : LIM_POS;
    assign q_sat    = (ovf_reg || (q_rnd > q_lim)) ? q_lim : q_rnd;
    assign q_signed = neg_reg ? -q_sat : q_sat;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        dcnt_next       = dcnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        in_hist_1_next  = in_hist_1_reg;
        in_hist_2_next  = in_hist_2_reg;
        out_hist_1_next = out_hist_1_reg;
        out_hist_2_next = out_hist_2_reg;
        kind_next       = kind_reg;
        x_next          = x_reg;
        prod_next       = prod_reg;
        prod_sub_next   = prod_sub_reg;
        acc_next        = acc_reg;
        dmag_next       = dmag_reg;
        neg_next        = neg_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        ovf_next        = ovf_reg;
        out_data_next   = out_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    x_next     = sample;
                    step_next  = '0;
                    acc_next   = kind ? '0 : ACC_ROUND;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (step_reg != step_last)
                begin
                    prod_next     = mul_prod;
                    prod_sub_next = (step_reg == 3'd3) || (step_reg == 3'd4);
                end
                if (step_reg != '0)
                begin
                    if (prod_sub_reg)
                        acc_next = acc_reg - ACC_BITS'(prod_reg);
                    else
                        acc_next = acc_reg + ACC_BITS'(prod_reg);
                end
                if (step_reg == step_last)
                    state_next = kind_reg ? S_DEN : S_FIN;
                else
                    step_next = step_reg + 3'd1;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = res_sat;
                    in_hist_2_next  = in_hist_1_reg;
                    in_hist_1_next  = x_reg;
                    out_hist_2_next = out_hist_1_reg;
                    out_hist_1_next = res_sat;
                    state_next      = S_IDLE;
                end
            end
            S_DEN:
            begin
                in_hist_1_next = x_reg;
                in_hist_2_next = x_reg;
                if (den == '0)
                begin
                    out_hist_1_next = '0;
                    out_hist_2_next = '0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    dmag_next  = DMAG_BITS'(den[DEN_BITS-1] ? -den : den);
                    neg_next   = acc_reg[ACC_BITS-1] ^ den[DEN_BITS-1];
                    dvd_next   = acc_mag[MAG_BITS-1:0];
                    rem_next   = '0;
                    quo_next   = '0;
                    ovf_next   = 1'b0;
                    dcnt_next  = DCNT_LAST;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = fits ? DMAG_BITS'(trial - {1'b0, dmag_reg})
                                : trial[DMAG_BITS-1:0];
                dvd_next = {dvd_reg[MAG_BITS-2:0], 1'b0};
                quo_next = {quo_reg[QUO_BITS-2:0], fits};
                ovf_next = ovf_reg | quo_reg[QUO_BITS-1];
                if (dcnt_reg == '0)
                    state_next = S_PFIN;
                else
                    dcnt_next = dcnt_reg - DCNT_BITS'(1);
            end
            S_PFIN:
            begin
                out_hist_1_next = sample_t'(q_signed);
                out_hist_2_next = sample_t'(q_signed);
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            dcnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
            ff_gain_0_reg  <= COEF_ONE;
            ff_gain_1_reg  <= '0;
            ff_gain_2_reg  <= '0;
            fb_gain_1_reg  <= '0;
            fb_gain_2_reg  <= '0;
            in_hist_1_reg  <= '0;
            in_hist_2_reg  <= '0;
            out_hist_1_reg <= '0;
            out_hist_2_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            dcnt_reg       <= dcnt_next;
            out_valid_reg  <= out_valid_next;
            in_hist_1_reg  <= in_hist_1_next;
            in_hist_2_reg  <= in_hist_2_next;
            out_hist_1_reg <= out_hist_1_next;
            out_hist_2_reg <= out_hist_2_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_FF_GAIN_0: ff_gain_0_reg <= cfg_data;
                    REG_FF_GAIN_1: ff_gain_1_reg <= cfg_data;
                    REG_FF_GAIN_2: ff_gain_2_reg <= cfg_data;
                    REG_FB_GAIN_1: fb_gain_1_reg <= cfg_data;
                    REG_FB_GAIN_2: fb_gain_2_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        x_reg        <= x_next;
        prod_reg     <= prod_next;
        prod_sub_reg <= prod_sub_next;
        acc_reg      <= acc_next;
        dmag_reg     <= dmag_next;
        neg_reg      <= neg_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        ovf_reg      <= ovf_next;
        out_data_reg <= out_data_next;
    end

    // a result shows up only from the filter finish step
    `BQD_ASSERT_NEXT(a_no_stray_result, !out_valid_reg && (state_reg != S_FIN), !out_valid_reg)

    // the divider never runs on a zero divisor
    `BQD_ASSERT_SAME(a_div_nonzero, (state_reg == S_DIV) || (state_reg == S_PFIN), dmag_reg != '0)

    // every input transfer starts the product sequence from its first step
    `BQD_ASSERT_NEXT(a_start_mac, in_valid && in_ready, (state_reg == S_MAC) && (step_reg == '0))

endmodule

`default_nettype wire
